// ===== rtl/etrb_pkg.sv =====
// Shared types and constants for the event trace ring buffer.
`timescale 1ns / 1ps
package etrb_pkg;

    // request operation codes
    localparam logic OP_LOG  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // configuration register indexes and reset values
    localparam logic REG_TIME_WRAP_CODE = 1'b0;
    localparam logic REG_MARKER_CODE    = 1'b1;
    localparam logic [7:0] TIME_WRAP_CODE_RST = 8'd1;
    localparam logic [7:0] MARKER_CODE_RST    = 8'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRAP,
        ST_EVENT,
        ST_READ
    } t_state;

    typedef struct packed {
        logic [31:0] stamp;
        logic [7:0]  code;
        logic [31:0] value;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic load_log;   // capture log payload, update last stamp
        logic wr_wrap;    // store time-wrap entry
        logic wr_event;   // store event entry, emit log result
        logic rd_finish;  // read data ready, emit read result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic stamp_back; // incoming stamp below last logged stamp
    } t_status;

endpackage

// ===== rtl/etrb_cfg.sv =====
// APB register file holding the time-wrap and overwrite-marker codes.
`timescale 1ns / 1ps
module etrb_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  o_wrap_code,
    output logic [7:0]  o_marker_code
);
    import etrb_pkg::*;

    logic [7:0] r_wrap_code;
    logic [7:0] r_marker_code;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_code   <= TIME_WRAP_CODE_RST;
            r_marker_code <= MARKER_CODE_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_TIME_WRAP_CODE: r_wrap_code   <= pwdata[7:0];
                REG_MARKER_CODE:    r_marker_code <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TIME_WRAP_CODE: prdata = {24'b0, r_wrap_code};
            REG_MARKER_CODE:    prdata = {24'b0, r_marker_code};
            default:            prdata = 32'b0;
        endcase
    end

    assign o_wrap_code   = r_wrap_code;
    assign o_marker_code = r_marker_code;

endmodule

// ===== rtl/etrb_ctrl.sv =====
// Sequencing state machine for log and read requests.
`timescale 1ns / 1ps
module etrb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             i_operation,
    input  etrb_pkg::t_status i_status,
    output logic             busy,
    output etrb_pkg::t_cmd   o_cmd
);
    import etrb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_operation == OP_READ) begin
                        n_state = ST_READ;
                    end else if (i_status.stamp_back) begin
                        n_state = ST_WRAP;
                    end else begin
                        n_state = ST_EVENT;
                    end
                end
            end
            ST_WRAP:  n_state = ST_EVENT;
            ST_EVENT: n_state = ST_IDLE;
            ST_READ:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy           = (r_state != ST_IDLE);
        o_cmd.load_log = (r_state == ST_IDLE) && start && (i_operation == OP_LOG);
        o_cmd.wr_wrap  = (r_state == ST_WRAP);
        o_cmd.wr_event = (r_state == ST_EVENT);
        o_cmd.rd_finish = (r_state == ST_READ);
    end

endmodule

// ===== rtl/etrb_datapath.sv =====
// Entry memory, ring pointers, counters and result registers.
`timescale 1ns / 1ps
module etrb_datapath #(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  etrb_pkg::t_cmd     i_cmd,
    output etrb_pkg::t_status  o_status,
    input  logic signed [31:0] i_stamp,
    input  logic [7:0]         i_event_code,
    input  logic signed [31:0] i_event_value,
    input  logic [7:0]         i_wrap_code,
    input  logic [7:0]         i_marker_code,
    output logic               o_result_valid,
    output logic               o_item_valid,
    output logic signed [31:0] o_item_stamp,
    output logic [7:0]         o_item_code,
    output logic signed [31:0] o_item_value,
    output logic [5:0]         o_stored_count
);
    import etrb_pkg::*;

    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);

    t_entry mem [DEPTH];
    t_entry r_rd_entry;
    t_entry wr_entry;

    logic [SLOT_W-1:0] r_write_slot;
    logic [SLOT_W-1:0] r_oldest_slot;
    logic [SLOT_W-1:0] r_count;
    logic [30:0]       r_dropped;
    logic [31:0]       r_last_stamp;

    logic [31:0] r_stamp;
    logic [7:0]  r_code;
    logic [31:0] r_value;

    logic              r_result_valid;
    logic              r_item_valid;
    logic [31:0]       r_item_stamp;
    logic [7:0]        r_item_code;
    logic [31:0]       r_item_value;

    logic [SLOT_W-1:0] write_next;
    logic [SLOT_W-1:0] oldest_next;
    logic              store;
    logic              ring_full_hit;
    logic              not_empty;
    logic [SLOT_W+5:0] count_ext;

    assign write_next    = (r_write_slot == LAST_SLOT) ? '0 : r_write_slot + 1'b1;
    assign oldest_next   = (r_oldest_slot == LAST_SLOT) ? '0 : r_oldest_slot + 1'b1;
    assign store         = i_cmd.wr_wrap | i_cmd.wr_event;
    assign ring_full_hit = (write_next == r_oldest_slot);
    assign not_empty     = (r_oldest_slot != r_write_slot);

    assign o_status.stamp_back = ($signed(i_stamp) < $signed(r_last_stamp));

    always_comb begin
        wr_entry.stamp = r_stamp;
        if (i_cmd.wr_wrap) begin
            wr_entry.code  = i_wrap_code;
            wr_entry.value = r_stamp;
        end else begin
            wr_entry.code  = r_code;
            wr_entry.value = r_value;
        end
    end

    // entry memory: one write port, registered read at the oldest slot
    always_ff @(posedge i_clk) begin
        if (store) begin
            mem[r_write_slot] <= wr_entry;
        end
        r_rd_entry <= mem[r_oldest_slot];
    end

    // captured log payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_log) begin
            r_stamp <= i_stamp;
            r_code  <= i_event_code;
            r_value <= i_event_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_slot   <= '0;
            r_oldest_slot  <= '0;
            r_count        <= '0;
            r_dropped      <= '0;
            r_last_stamp   <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= i_cmd.wr_event | i_cmd.rd_finish;
            if (i_cmd.load_log) begin
                r_last_stamp <= i_stamp;
            end
            if (store) begin
                r_write_slot <= write_next;
                if (ring_full_hit) begin
                    // ring full: oldest entry dropped
                    r_oldest_slot <= oldest_next;
                    if (r_dropped != '1) begin
                        r_dropped <= r_dropped + 1'b1;
                    end
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.rd_finish && not_empty) begin
                if (r_dropped != '0) begin
                    r_dropped <= '0;
                end else begin
                    r_oldest_slot <= oldest_next;
                    if (r_count != '0) begin
                        r_count <= r_count - 1'b1;
                    end
                end
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_event || (i_cmd.rd_finish && !not_empty)) begin
            r_item_valid <= 1'b0;
            r_item_stamp <= '0;
            r_item_code  <= '0;
            r_item_value <= '0;
        end else if (i_cmd.rd_finish) begin
            r_item_valid <= 1'b1;
            r_item_stamp <= r_rd_entry.stamp;
            if (r_dropped != '0) begin
                r_item_code  <= i_marker_code;
                r_item_value <= {1'b0, r_dropped};
            end else begin
                r_item_code  <= r_rd_entry.code;
                r_item_value <= r_rd_entry.value;
            end
        end
    end

    assign count_ext      = {6'b0, r_count};
    assign o_result_valid = r_result_valid;
    assign o_item_valid   = r_item_valid;
    assign o_item_stamp   = r_item_stamp;
    assign o_item_code    = r_item_code;
    assign o_item_value   = r_item_value;
    assign o_stored_count = count_ext[5:0];

endmodule

// ===== rtl/event_trace_ring_buffer.sv =====
// Top level of the event trace ring buffer: controller, datapath and registers.
`timescale 1ns / 1ps
// Sequence: a log passes through the wrap state (only when the stamp goes
//   back) and the event state, a read through the read state.
// Requests are accepted only in idle, while busy is low; the result beat of
//   one request can overlap the acceptance of the next.
// Reset: synchronous on i_rst_n low; pointers, counts and last stamp clear,
//   config codes return to 1 and 2; memory contents are not cleared.
// The receiver cannot stall: each result beat is shown for one cycle only.
module event_trace_ring_buffer #(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               start,
    output logic               busy,
    input  logic               i_operation,
    input  logic signed [31:0] i_stamp,
    input  logic [7:0]         i_event_code,
    input  logic signed [31:0] i_event_value,
    // result channel
    output logic               o_result_valid,
    output logic               o_item_valid,
    output logic signed [31:0] o_item_stamp,
    output logic [7:0]         o_item_code,
    output logic signed [31:0] o_item_value,
    output logic [5:0]         o_stored_count,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import etrb_pkg::*;

    t_cmd       cmd;
    t_status    status;
    logic [7:0] wrap_code;
    logic [7:0] marker_code;

    // register file: codes for wrap entries and overwrite markers
    etrb_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_wrap_code   (wrap_code),
        .o_marker_code (marker_code)
    );

    // controller: idle -> (wrap) -> event for logs, idle -> read for reads
    etrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_status    (status),
        .busy        (busy),
        .o_cmd       (cmd)
    );

    // datapath: entry memory, ring pointers, drop counter, result registers
    etrb_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_stamp        (i_stamp),
        .i_event_code   (i_event_code),
        .i_event_value  (i_event_value),
        .i_wrap_code    (wrap_code),
        .i_marker_code  (marker_code),
        .o_result_valid (o_result_valid),
        .o_item_valid   (o_item_valid),
        .o_item_stamp   (o_item_stamp),
        .o_item_code    (o_item_code),
        .o_item_value   (o_item_value),
        .o_stored_count (o_stored_count)
    );

endmodule
